>>> sv/bt2d_pkg.sv
// ----------------------------------------------------------------------------
// bt2d_pkg
// Shared types and constants of the bilinear table lookup unit.
// ----------------------------------------------------------------------------
package bt2d_pkg;

    localparam int NPTS   = 16;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int VAL_W  = 16;
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = VAL_W + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DEN_W  = 2 * DIFF_W;
    localparam int NUM_W  = SUM_W + DIFF_W + 1;
    localparam int QUO_W  = VAL_W + 1;
    localparam int BANKS  = 4;
    localparam int BANK_DEPTH = NPTS * NPTS / BANKS;

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_Y = 2'd1,
        OP_LOAD_T = 2'd2,
        OP_EVAL   = 2'd3
    } op_t;

    localparam logic [2:0] MODE_EXTRAP  = 3'd0;
    localparam logic [2:0] MODE_CLAMP   = 3'd1;
    localparam logic [2:0] MODE_NEAREST = 3'd2;
    localparam logic [2:0] MODE_BELOW   = 3'd3;
    localparam logic [2:0] MODE_ABOVE   = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [1:0] CFG_X_POINTS = 2'd0;
    localparam logic [1:0] CFG_Y_POINTS = 2'd1;
    localparam logic [1:0] CFG_MODE     = 2'd2;

    typedef struct packed {
        logic                     valid;
        logic signed [NUM_W-1:0]  num;
        logic signed [DEN_W-1:0]  den;
    } div_in_t;

    typedef struct packed {
        logic                     valid;
        logic signed [VAL_W-1:0]  result;
        logic [1:0]               status;
    } div_out_t;

    typedef struct packed {
        logic valid;
        logic zero;
        logic neg;
        logic big;
    } div_ctl_t;

endpackage

>>> sv/bt2d_ram.sv
// ----------------------------------------------------------------------------
// bt2d_ram
// Simple dual-port RAM, one write and one registered read, read-first.
// ----------------------------------------------------------------------------
module bt2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bt2d_divider.sv
// ----------------------------------------------------------------------------
// bt2d_divider
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and saturating to the result range.
// ----------------------------------------------------------------------------
module bt2d_divider
    import bt2d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_in_t  din,
    output div_out_t dout
);

    localparam logic [QUO_W-1:0] LIM_POS = QUO_W'((2 ** (VAL_W - 1)) - 1);
    localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(2 ** (VAL_W - 1));

    logic                    d0_valid_reg;
    logic signed [NUM_W-1:0] d0_num_reg;
    logic signed [DEN_W-1:0] d0_den_reg;

    div_ctl_t                d1_ctl_reg;
    logic [NUM_W-1:0]        d1_nmag_reg;
    logic [DEN_W-1:0]        d1_dmag_reg;
    logic                    d1_big;

    div_ctl_t                ctl_reg  [QUO_W+1];
    logic [NUM_W-1:0]        rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]        quo_reg  [QUO_W+1];
    logic [DEN_W-1:0]        dmag_reg [QUO_W+1];

    div_out_t                out_reg;
    div_out_t                out_next;

    // quotient would not fit in QUO_W bits
    assign d1_big = (d1_nmag_reg >= (NUM_W'(d1_dmag_reg) << QUO_W));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_valid_reg <= 1'b0;
            d1_ctl_reg   <= '0;
            ctl_reg[0]   <= '0;
        end
        else
        begin
            d0_valid_reg <= din.valid;
            d1_ctl_reg   <= {d0_valid_reg, (d0_den_reg == '0),
                             d0_num_reg[NUM_W-1] ^ d0_den_reg[DEN_W-1], 1'b0};
            ctl_reg[0]   <= {d1_ctl_reg.valid, d1_ctl_reg.zero, d1_ctl_reg.neg, d1_big};
        end
    end

    always_ff @(posedge clk)
    begin
        d0_num_reg  <= din.num;
        d0_den_reg  <= din.den;
        d1_nmag_reg <= d0_num_reg[NUM_W-1] ? NUM_W'(-d0_num_reg) : NUM_W'(d0_num_reg);
        d1_dmag_reg <= d0_den_reg[DEN_W-1] ? DEN_W'(-d0_den_reg) : DEN_W'(d0_den_reg);
        rem_reg[0]  <= d1_nmag_reg;
        quo_reg[0]  <= '0;
        dmag_reg[0] <= d1_dmag_reg;
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - s;

        logic [NUM_W-1:0] trial;
        logic             fits;

        assign trial = NUM_W'(dmag_reg[s]) << BIT;
        assign fits  = (rem_reg[s] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s+1] <= '0;
            end
            else
            begin
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s+1]  <= fits ? NUM_W'(rem_reg[s] - trial) : rem_reg[s];
            quo_reg[s+1]  <= quo_reg[s] | (QUO_W'(fits) << BIT);
            dmag_reg[s+1] <= dmag_reg[s];
        end
    end

    always_comb
    begin
        div_ctl_t         c;
        logic [QUO_W-1:0] q;
        c = ctl_reg[QUO_W];
        q = quo_reg[QUO_W];
        out_next.valid = c.valid;
        if (c.zero)
        begin
            out_next.result = '0;
            out_next.status = ST_ZERO;
        end
        else if (c.big || (!c.neg && q > LIM_POS) || (c.neg && q > LIM_NEG))
        begin
            out_next.result = c.neg ? VAL_W'(LIM_NEG) : VAL_W'(LIM_POS);
            out_next.status = ST_SAT;
        end
        else
        begin
            out_next.result = c.neg ? VAL_W'(-q) : VAL_W'(q);
            out_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

>>> sv/bilinear_table_2d_lookup_unit.sv
// ----------------------------------------------------------------------------
// bilinear_table_2d_lookup_unit
// Two-dimensional breakpoint table with bilinear interpolation, Q8.8.
//
// Usage:
//   An item is taken at a clock edge with start high and busy low. busy is
//   always low, so one item can be taken every cycle. Load items write x
//   breakpoints, y breakpoints or table values and give no result. Each
//   evaluate item gives one result on result/status, marked by done for a
//   single cycle.
//   Throughput is one item per cycle; the latency is set by the 17-stage
//   quotient pipeline behind seven stages of cell search and products.
//   The table sits in four RAM banks split by row and column parity, so the
//   four corners of a cell are read in the same cycle.
//   Configuration (x_points, y_points, mode) is written through cfg_valid,
//   cfg_ready, cfg_index and cfg_data; cfg_ready is always high.
//   Reset clears the pipeline and sets x_points = 2, y_points = 2, mode 0;
//   breakpoints and table values hold nothing until written.
//   The receiver cannot stall: each result must be taken in its done cycle.
// ----------------------------------------------------------------------------
module bilinear_table_2d_lookup_unit
    import bt2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic [IDX_W-1:0]        x_index,
    input  logic [IDX_W-1:0]        y_index,
    input  logic signed [VAL_W-1:0] load_value,
    input  logic signed [VAL_W-1:0] x_coord,
    input  logic signed [VAL_W-1:0] y_coord,
    output logic signed [VAL_W-1:0] result,
    output logic [1:0]              status,
    output logic                    done,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [CNT_W-1:0]        cfg_data
);

    localparam int BA_W = $clog2(BANK_DEPTH);

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] n;
        if (v < CNT_W'(2))
            n = CNT_W'(2);
        else if (v > CNT_W'(NPTS))
            n = CNT_W'(NPTS);
        else
            n = v;
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] find_cell(
        input logic             le0,
        input logic             gen,
        input logic [NPTS-1:0]  ge,
        input logic [CNT_W-1:0] n
    );
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] mid;
        logic [IDX_W-1:0] k;
        lo = '0;
        hi = CNT_W'(n - CNT_W'(1));
        for (int s = 0; s < IDX_W; s++)
        begin
            if (lo != CNT_W'(hi - CNT_W'(1)))
            begin
                mid = CNT_W'((lo + hi) >> 1);
                if (ge[mid[IDX_W-1:0]])
                    lo = mid;
                else
                    hi = mid;
            end
        end
        if (le0)
            k = IDX_W'(1);
        else if (gen)
            k = IDX_W'(n - CNT_W'(1));
        else
            k = hi[IDX_W-1:0];
        return k;
    endfunction

    function automatic logic signed [VAL_W-1:0] adjust(
        input logic signed [VAL_W-1:0] c,
        input logic signed [VAL_W-1:0] bpk,
        input logic signed [VAL_W-1:0] bpk1,
        input logic signed [VAL_W-1:0] bp0,
        input logic signed [VAL_W-1:0] bpn,
        input logic                    le0,
        input logic                    gen,
        input logic [2:0]              md
    );
        logic signed [DIFF_W-1:0] up;
        logic signed [DIFF_W-1:0] dn;
        logic signed [VAL_W-1:0]  a;
        up = DIFF_W'(bpk) - DIFF_W'(c);
        dn = DIFF_W'(c) - DIFF_W'(bpk1);
        if (md < MODE_CLAMP || md > MODE_ABOVE)
            a = c;
        else if (gen)
            a = bpn;
        else if (le0)
            a = bp0;
        else
        begin
            case (md)
                MODE_NEAREST: a = (up > dn) ? bpk1 : bpk;
                MODE_BELOW:   a = (c < bpk) ? bpk1 : c;
                MODE_ABOVE:   a = (c > bpk1) ? bpk : c;
                default:      a = c;
            endcase
        end
        return a;
    endfunction

    // configuration
    logic [CNT_W-1:0] x_pts_reg;
    logic [CNT_W-1:0] y_pts_reg;
    logic [2:0]       mode_reg;
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_pts_reg <= CNT_W'(2);
            y_pts_reg <= CNT_W'(2);
            mode_reg  <= MODE_EXTRAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_X_POINTS: x_pts_reg <= cfg_data;
                CFG_Y_POINTS: y_pts_reg <= cfg_data;
                CFG_MODE:     mode_reg  <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    assign nx = clamp_count(x_pts_reg);
    assign ny = clamp_count(y_pts_reg);

    // stage 1: breakpoint writes, compare against every breakpoint
    logic                    s1_valid_reg;
    op_t                     s1_op_reg;
    logic [IDX_W-1:0]        s1_xi_reg;
    logic [IDX_W-1:0]        s1_yi_reg;
    logic signed [VAL_W-1:0] s1_lv_reg;
    logic signed [VAL_W-1:0] s1_x_reg;
    logic signed [VAL_W-1:0] s1_y_reg;

    logic signed [VAL_W-1:0] xbp_reg [NPTS];
    logic signed [VAL_W-1:0] ybp_reg [NPTS];

    logic [NPTS-1:0]         s1_xge;
    logic [NPTS-1:0]         s1_yge;
    logic signed [VAL_W-1:0] s1_xbpn;
    logic signed [VAL_W-1:0] s1_ybpn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg <= op_t'(operation);
        s1_xi_reg <= x_index;
        s1_yi_reg <= y_index;
        s1_lv_reg <= load_value;
        s1_x_reg  <= x_coord;
        s1_y_reg  <= y_coord;
        if (s1_valid_reg && s1_op_reg == OP_LOAD_X)
            xbp_reg[s1_xi_reg] <= s1_lv_reg;
        if (s1_valid_reg && s1_op_reg == OP_LOAD_Y)
            ybp_reg[s1_yi_reg] <= s1_lv_reg;
    end

    always_comb
    begin
        for (int m = 0; m < NPTS; m++)
        begin
            s1_xge[m] = (s1_x_reg >= xbp_reg[m]);
            s1_yge[m] = (s1_y_reg >= ybp_reg[m]);
        end
    end

    assign s1_xbpn = xbp_reg[IDX_W'(nx - CNT_W'(1))];
    assign s1_ybpn = ybp_reg[IDX_W'(ny - CNT_W'(1))];

    // stage 2: cell search, corner breakpoints
    logic                    s2_valid_reg;
    op_t                     s2_op_reg;
    logic [IDX_W-1:0]        s2_xi_reg;
    logic [IDX_W-1:0]        s2_yi_reg;
    logic signed [VAL_W-1:0] s2_lv_reg;
    logic signed [VAL_W-1:0] s2_x_reg;
    logic signed [VAL_W-1:0] s2_y_reg;
    logic [NPTS-1:0]         s2_xge_reg;
    logic [NPTS-1:0]         s2_yge_reg;
    logic                    s2_xle0_reg;
    logic                    s2_yle0_reg;
    logic                    s2_xgen_reg;
    logic                    s2_ygen_reg;
    logic signed [VAL_W-1:0] s2_xbp0_reg;
    logic signed [VAL_W-1:0] s2_ybp0_reg;
    logic signed [VAL_W-1:0] s2_xbpn_reg;
    logic signed [VAL_W-1:0] s2_ybpn_reg;
    logic [IDX_W-1:0]        s2_kx;
    logic [IDX_W-1:0]        s2_ky;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg   <= s1_op_reg;
        s2_xi_reg   <= s1_xi_reg;
        s2_yi_reg   <= s1_yi_reg;
        s2_lv_reg   <= s1_lv_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        s2_xge_reg  <= s1_xge;
        s2_yge_reg  <= s1_yge;
        s2_xle0_reg <= (s1_x_reg <= xbp_reg[0]);
        s2_yle0_reg <= (s1_y_reg <= ybp_reg[0]);
        s2_xgen_reg <= (s1_x_reg >= s1_xbpn);
        s2_ygen_reg <= (s1_y_reg >= s1_ybpn);
        s2_xbp0_reg <= xbp_reg[0];
        s2_ybp0_reg <= ybp_reg[0];
        s2_xbpn_reg <= s1_xbpn;
        s2_ybpn_reg <= s1_ybpn;
    end

    assign s2_kx = find_cell(s2_xle0_reg, s2_xgen_reg, s2_xge_reg, nx);
    assign s2_ky = find_cell(s2_yle0_reg, s2_ygen_reg, s2_yge_reg, ny);

    // stage 3: coordinate adjust, distances, table read and write
    logic                    s3_valid_reg;
    op_t                     s3_op_reg;
    logic [IDX_W-1:0]        s3_xi_reg;
    logic [IDX_W-1:0]        s3_yi_reg;
    logic signed [VAL_W-1:0] s3_lv_reg;
    logic signed [VAL_W-1:0] s3_x_reg;
    logic signed [VAL_W-1:0] s3_y_reg;
    logic [IDX_W-1:0]        s3_kx_reg;
    logic [IDX_W-1:0]        s3_ky_reg;
    logic signed [VAL_W-1:0] s3_xbpk_reg;
    logic signed [VAL_W-1:0] s3_xbpk1_reg;
    logic signed [VAL_W-1:0] s3_ybpk_reg;
    logic signed [VAL_W-1:0] s3_ybpk1_reg;
    logic signed [VAL_W-1:0] s3_xbp0_reg;
    logic signed [VAL_W-1:0] s3_ybp0_reg;
    logic signed [VAL_W-1:0] s3_xbpn_reg;
    logic signed [VAL_W-1:0] s3_ybpn_reg;
    logic                    s3_xle0_reg;
    logic                    s3_yle0_reg;
    logic                    s3_xgen_reg;
    logic                    s3_ygen_reg;
    logic signed [VAL_W-1:0] s3_xa;
    logic signed [VAL_W-1:0] s3_ya;
    logic [IDX_W-1:0]        s3_kx1;
    logic [IDX_W-1:0]        s3_ky1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_op_reg    <= s2_op_reg;
        s3_xi_reg    <= s2_xi_reg;
        s3_yi_reg    <= s2_yi_reg;
        s3_lv_reg    <= s2_lv_reg;
        s3_x_reg     <= s2_x_reg;
        s3_y_reg     <= s2_y_reg;
        s3_kx_reg    <= s2_kx;
        s3_ky_reg    <= s2_ky;
        s3_xbpk_reg  <= xbp_reg[s2_kx];
        s3_xbpk1_reg <= xbp_reg[IDX_W'(s2_kx - IDX_W'(1))];
        s3_ybpk_reg  <= ybp_reg[s2_ky];
        s3_ybpk1_reg <= ybp_reg[IDX_W'(s2_ky - IDX_W'(1))];
        s3_xbp0_reg  <= s2_xbp0_reg;
        s3_ybp0_reg  <= s2_ybp0_reg;
        s3_xbpn_reg  <= s2_xbpn_reg;
        s3_ybpn_reg  <= s2_ybpn_reg;
        s3_xle0_reg  <= s2_xle0_reg;
        s3_yle0_reg  <= s2_yle0_reg;
        s3_xgen_reg  <= s2_xgen_reg;
        s3_ygen_reg  <= s2_ygen_reg;
    end

    assign s3_xa = adjust(s3_x_reg, s3_xbpk_reg, s3_xbpk1_reg, s3_xbp0_reg, s3_xbpn_reg,
                          s3_xle0_reg, s3_xgen_reg, mode_reg);
    assign s3_ya = adjust(s3_y_reg, s3_ybpk_reg, s3_ybpk1_reg, s3_ybp0_reg, s3_ybpn_reg,
                          s3_yle0_reg, s3_ygen_reg, mode_reg);
    assign s3_kx1 = IDX_W'(s3_kx_reg - IDX_W'(1));
    assign s3_ky1 = IDX_W'(s3_ky_reg - IDX_W'(1));

    logic [VAL_W-1:0] bank_rd [BANKS];

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        localparam logic RB = 1'(b / 2);
        localparam logic CB = 1'(b % 2);

        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [BA_W-1:0]  raddr;
        logic [BA_W-1:0]  waddr;
        logic             we;

        assign row   = (s3_ky1[0] == RB) ? s3_ky1 : s3_ky_reg;
        assign col   = (s3_kx1[0] == CB) ? s3_kx1 : s3_kx_reg;
        assign raddr = {row[IDX_W-1:1], col[IDX_W-1:1]};
        assign waddr = {s3_yi_reg[IDX_W-1:1], s3_xi_reg[IDX_W-1:1]};
        assign we    = s3_valid_reg && (s3_op_reg == OP_LOAD_T)
                       && (s3_yi_reg[0] == RB) && (s3_xi_reg[0] == CB);

        bt2d_ram #(
            .WIDTH (VAL_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (s3_lv_reg),
            .raddr (raddr),
            .rdata (bank_rd[b])
        );
    end

    // stage 4: corner products and cell area
    logic                     s4_valid_reg;
    logic signed [DIFF_W-1:0] s4_ax_reg;
    logic signed [DIFF_W-1:0] s4_bx_reg;
    logic signed [DIFF_W-1:0] s4_ay_reg;
    logic signed [DIFF_W-1:0] s4_by_reg;
    logic signed [DIFF_W-1:0] s4_dx_reg;
    logic signed [DIFF_W-1:0] s4_dy_reg;
    logic                     s4_kx0_reg;
    logic                     s4_ky0_reg;
    logic signed [VAL_W-1:0]  f11;
    logic signed [VAL_W-1:0]  f21;
    logic signed [VAL_W-1:0]  f12;
    logic signed [VAL_W-1:0]  f22;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg && (s3_op_reg == OP_EVAL);
    end

    always_ff @(posedge clk)
    begin
        s4_ax_reg  <= DIFF_W'(s3_xbpk_reg) - DIFF_W'(s3_xa);
        s4_bx_reg  <= DIFF_W'(s3_xa) - DIFF_W'(s3_xbpk1_reg);
        s4_ay_reg  <= DIFF_W'(s3_ybpk_reg) - DIFF_W'(s3_ya);
        s4_by_reg  <= DIFF_W'(s3_ya) - DIFF_W'(s3_ybpk1_reg);
        s4_dx_reg  <= DIFF_W'(s3_xbpk_reg) - DIFF_W'(s3_xbpk1_reg);
        s4_dy_reg  <= DIFF_W'(s3_ybpk_reg) - DIFF_W'(s3_ybpk1_reg);
        s4_kx0_reg <= s3_kx_reg[0];
        s4_ky0_reg <= s3_ky_reg[0];
    end

    assign f22 = $signed(bank_rd[{s4_ky0_reg, s4_kx0_reg}]);
    assign f11 = $signed(bank_rd[{~s4_ky0_reg, ~s4_kx0_reg}]);
    assign f21 = $signed(bank_rd[{~s4_ky0_reg, s4_kx0_reg}]);
    assign f12 = $signed(bank_rd[{s4_ky0_reg, ~s4_kx0_reg}]);

    // stage 5: x-axis sums
    logic                     s5_valid_reg;
    logic signed [PROD_W-1:0] s5_p11_reg;
    logic signed [PROD_W-1:0] s5_p21_reg;
    logic signed [PROD_W-1:0] s5_p12_reg;
    logic signed [PROD_W-1:0] s5_p22_reg;
    logic signed [DIFF_W-1:0] s5_ay_reg;
    logic signed [DIFF_W-1:0] s5_by_reg;
    logic signed [DEN_W-1:0]  s5_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_p11_reg <= f11 * s4_ax_reg;
        s5_p21_reg <= f21 * s4_bx_reg;
        s5_p12_reg <= f12 * s4_ax_reg;
        s5_p22_reg <= f22 * s4_bx_reg;
        s5_ay_reg  <= s4_ay_reg;
        s5_by_reg  <= s4_by_reg;
        s5_den_reg <= s4_dx_reg * s4_dy_reg;
    end

    // stage 6: y-axis products
    logic                     s6_valid_reg;
    logic signed [SUM_W-1:0]  s6_sx1_reg;
    logic signed [SUM_W-1:0]  s6_sx2_reg;
    logic signed [DIFF_W-1:0] s6_ay_reg;
    logic signed [DIFF_W-1:0] s6_by_reg;
    logic signed [DEN_W-1:0]  s6_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s6_sx1_reg <= SUM_W'(s5_p11_reg) + SUM_W'(s5_p21_reg);
        s6_sx2_reg <= SUM_W'(s5_p12_reg) + SUM_W'(s5_p22_reg);
        s6_ay_reg  <= s5_ay_reg;
        s6_by_reg  <= s5_by_reg;
        s6_den_reg <= s5_den_reg;
    end

    // stage 7: numerator terms, summed into the divider
    logic                    s7_valid_reg;
    logic signed [NUM_W-1:0] s7_t1_reg;
    logic signed [NUM_W-1:0] s7_t2_reg;
    logic signed [DEN_W-1:0] s7_den_reg;
    div_in_t                 div_in;
    div_out_t                div_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s7_t1_reg  <= NUM_W'(s6_sx1_reg) * NUM_W'(s6_ay_reg);
        s7_t2_reg  <= NUM_W'(s6_sx2_reg) * NUM_W'(s6_by_reg);
        s7_den_reg <= s6_den_reg;
    end

    assign div_in.valid = s7_valid_reg;
    assign div_in.num   = s7_t1_reg + s7_t2_reg;
    assign div_in.den   = s7_den_reg;

    bt2d_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (div_in),
        .dout  (div_out)
    );

    assign done   = div_out.valid;
    assign result = div_out.result;
    assign status = div_out.status;

endmodule

>>> tb/bilinear_table_2d_lookup_unit_tb.sv
// ----------------------------------------------------------------------------
// bilinear_table_2d_lookup_unit_tb
// Self-checking bench for the bilinear 2d table lookup unit.
//
// The table and both breakpoint sets are fully loaded first, so no unwritten
// entry is ever read. The run then steps through phases of point counts and
// modes, in range and out of range. Each phase reloads breakpoints (ascending,
// with duplicates, full span or unordered), runs a few directed lookups at
// the ends, on breakpoints and on cell midpoints, then random loads and
// lookups. An in-bench predictor computes each lookup, and the monitor
// compares every done cycle against the oldest prediction.
// ----------------------------------------------------------------------------
module bilinear_table_2d_lookup_unit_tb;
    import bt2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        op_t                     op;
        logic [IDX_W-1:0]        xi;
        logic [IDX_W-1:0]        yi;
        logic signed [VAL_W-1:0] lv;
        logic signed [VAL_W-1:0] xc;
        logic signed [VAL_W-1:0] yc;
    } lut_item_t;

    typedef struct {
        logic signed [VAL_W-1:0] res;
        logic [1:0]              st;
    } lut_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              operation = 2'd0;
    logic [IDX_W-1:0]        x_index = '0;
    logic [IDX_W-1:0]        y_index = '0;
    logic signed [VAL_W-1:0] load_value = '0;
    logic signed [VAL_W-1:0] x_coord = '0;
    logic signed [VAL_W-1:0] y_coord = '0;
    logic signed [VAL_W-1:0] result;
    logic [1:0]              status;
    logic                    done;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = '0;
    logic [CNT_W-1:0]        cfg_data = '0;

    lut_item_t pending_items[$];
    lut_res_t  expected_lookups[$];
    lut_item_t cur_item;
    int        idle_pct = 0;
    int        errors = 0;
    int        lookups_checked = 0;
    int        items_sent = 0;

    // predictor state
    longint    mdl_xb[NPTS];
    longint    mdl_yb[NPTS];
    longint    mdl_tab[NPTS][NPTS];
    logic [CNT_W-1:0] mdl_xpts = 5'd2;
    logic [CNT_W-1:0] mdl_ypts = 5'd2;
    logic [2:0]       mdl_mode = MODE_EXTRAP;

    // generator shadow of breakpoints
    longint    gen_xb[NPTS];
    longint    gen_yb[NPTS];

    bilinear_table_2d_lookup_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .x_index(x_index), .y_index(y_index),
        .load_value(load_value), .x_coord(x_coord), .y_coord(y_coord),
        .result(result), .status(status), .done(done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int eff_points(logic [CNT_W-1:0] v);
        if (v < 2) return 2;
        if (v > NPTS) return NPTS;
        return int'(v);
    endfunction

    function automatic int find_cell(longint c, int n, longint bp[NPTS]);
        int lo;
        int hi;
        int mid;
        if (c <= bp[0]) return 1;
        if (c >= bp[n-1]) return n - 1;
        lo = 0;
        hi = n - 1;
        while (lo != hi - 1)
        begin
            mid = (lo + hi) / 2;
            if (c >= bp[mid]) lo = mid;
            else hi = mid;
        end
        return hi;
    endfunction

    function automatic longint snap_coord(longint c, int k, int n, longint bp[NPTS],
                                          logic [2:0] md);
        if (md < MODE_CLAMP || md > MODE_ABOVE) return c;
        if (c >= bp[n-1]) return bp[n-1];
        if (c <= bp[0]) return bp[0];
        if (md == MODE_NEAREST) return ((bp[k] - c) > (c - bp[k-1])) ? bp[k-1] : bp[k];
        if (md == MODE_BELOW) return (c < bp[k]) ? bp[k-1] : c;
        if (md == MODE_ABOVE) return (c > bp[k-1]) ? bp[k] : c;
        return c;
    endfunction

    function automatic lut_res_t interpolate(longint xc, longint yc);
        lut_res_t r;
        int       nx;
        int       ny;
        int       i;
        int       j;
        longint   x;
        longint   y;
        longint   den;
        longint   num;
        longint   q;
        longint   ax;
        longint   bx;
        longint   ay;
        longint   by;
        nx = eff_points(mdl_xpts);
        ny = eff_points(mdl_ypts);
        i = find_cell(xc, nx, mdl_xb);
        j = find_cell(yc, ny, mdl_yb);
        x = snap_coord(xc, i, nx, mdl_xb, mdl_mode);
        y = snap_coord(yc, j, ny, mdl_yb, mdl_mode);
        den = (mdl_xb[i] - mdl_xb[i-1]) * (mdl_yb[j] - mdl_yb[j-1]);
        if (den == 0)
        begin
            r.res = '0;
            r.st = ST_ZERO;
            return r;
        end
        ax = mdl_xb[i] - x;
        bx = x - mdl_xb[i-1];
        ay = mdl_yb[j] - y;
        by = y - mdl_yb[j-1];
        num = (mdl_tab[j-1][i-1] * ax + mdl_tab[j-1][i] * bx) * ay
            + (mdl_tab[j][i-1] * ax + mdl_tab[j][i] * bx) * by;
        q = num / den;
        r.st = ST_OK;
        if (q > 32767)
        begin
            q = 32767;
            r.st = ST_SAT;
        end
        else if (q < -32768)
        begin
            q = -32768;
            r.st = ST_SAT;
        end
        r.res = q[VAL_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            items_sent <= items_sent + 1;
            case (cur_item.op)
                OP_LOAD_X: mdl_xb[cur_item.xi] = longint'(cur_item.lv);
                OP_LOAD_Y: mdl_yb[cur_item.yi] = longint'(cur_item.lv);
                OP_LOAD_T: mdl_tab[cur_item.yi][cur_item.xi] = longint'(cur_item.lv);
                default:   expected_lookups.push_back(
                               interpolate(longint'(cur_item.xc), longint'(cur_item.yc)));
            endcase
        end
        if (!(start && busy))
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_item = pending_items.pop_front();
                start <= 1'b1;
                operation <= cur_item.op;
                x_index <= cur_item.xi;
                y_index <= cur_item.yi;
                load_value <= cur_item.lv;
                x_coord <= cur_item.xc;
                y_coord <= cur_item.yc;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t unexpected result: actual %0d status %0d", $time, result, status);
                errors++;
            end
            else
            begin
                lut_res_t e;
                e = expected_lookups.pop_front();
                lookups_checked++;
                if (result !== e.res)
                begin
                    $display("%0t result mismatch: expected %0d actual %0d", $time, e.res,
                             result);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time, e.st,
                             status);
                    errors++;
                end
            end
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_X_POINTS) mdl_xpts = val;
        else if (idx == CFG_Y_POINTS) mdl_ypts = val;
        else if (idx == CFG_MODE) mdl_mode = val[2:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || start || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic lut_item_t mk_item(op_t op, int xi, int yi, longint lv,
                                          longint xc, longint yc);
        lut_item_t it;
        it.op = op;
        it.xi = xi[IDX_W-1:0];
        it.yi = yi[IDX_W-1:0];
        it.lv = lv[VAL_W-1:0];
        it.xc = xc[VAL_W-1:0];
        it.yc = yc[VAL_W-1:0];
        return it;
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic load_breaks(int kind);
        longint v;
        longint b;
        for (int ax = 0; ax < 2; ax++)
        begin
            v = -20000 + $urandom_range(8000);
            for (int k = 0; k < NPTS; k++)
            begin
                case (kind)
                    0: b = v + $urandom_range(2500);
                    1: b = ($urandom_range(3) == 0) ? v : v + $urandom_range(2000);
                    2: b = longint'($signed(16'($urandom)));
                    default: b = -32768 + k * 4369;
                endcase
                b = clip16(b);
                if (kind == 0 || kind == 1) v = b;
                if (ax == 0)
                begin
                    gen_xb[k] = b;
                    pending_items.push_back(mk_item(OP_LOAD_X, k, $urandom_range(15), b,
                                            $urandom, $urandom));
                end
                else
                begin
                    gen_yb[k] = b;
                    pending_items.push_back(mk_item(OP_LOAD_Y, $urandom_range(15), k, b,
                                            $urandom, $urandom));
                end
            end
        end
    endtask

    function automatic longint pick_coord(int n, longint bp[NPTS]);
        int     k;
        longint lo;
        longint hi;
        k = $urandom_range(n - 2);
        lo = (bp[0] < bp[n-1]) ? bp[0] : bp[n-1];
        hi = (bp[0] < bp[n-1]) ? bp[n-1] : bp[0];
        case ($urandom_range(7))
            0: return longint'($signed(16'($urandom)));
            1: return bp[$urandom_range(n - 1)];
            2: return (bp[k] + bp[k+1]) >>> 1;
            3: return clip16(lo - $urandom_range(3000));
            4: return clip16(hi + $urandom_range(3000));
            default: return lo + $urandom_range(int'(hi - lo));
        endcase
    endfunction

    task automatic add_lookup(longint xc, longint yc);
        pending_items.push_back(mk_item(OP_EVAL, $urandom_range(15), $urandom_range(15),
                                        $urandom, xc, yc));
    endtask

    task automatic run_phase(int xp, int yp, int md, int kind, int n_items);
        int     nx;
        int     ny;
        int     r;
        longint lv;
        write_cfg(CFG_X_POINTS, xp[CNT_W-1:0]);
        write_cfg(CFG_Y_POINTS, yp[CNT_W-1:0]);
        write_cfg(CFG_MODE, md[CNT_W-1:0]);
        nx = eff_points(xp[CNT_W-1:0]);
        ny = eff_points(yp[CNT_W-1:0]);
        load_breaks(kind);
        add_lookup(32767, 32767);
        add_lookup(-32768, -32768);
        add_lookup(32767, -32768);
        add_lookup(gen_xb[0], gen_yb[ny-1]);
        add_lookup((gen_xb[0] + gen_xb[1]) >>> 1, (gen_yb[0] + gen_yb[1]) >>> 1);
        add_lookup(gen_xb[nx-1], gen_yb[0]);
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(99);
            if (r < 65)
                add_lookup(pick_coord(nx, gen_xb), pick_coord(ny, gen_yb));
            else if (r < 90)
            begin
                lv = ($urandom_range(3) == 0) ? longint'($signed(16'($urandom)))
                                              : longint'($urandom_range(2048)) - 1024;
                pending_items.push_back(mk_item(OP_LOAD_T, $urandom_range(15),
                                        $urandom_range(15), lv, $urandom, $urandom));
            end
            else
            begin
                int k;
                k = $urandom_range(NPTS - 1);
                if (r < 95)
                begin
                    lv = (k > 0 && k < NPTS - 1)
                       ? gen_xb[k-1] + $urandom_range(int'(gen_xb[k+1] > gen_xb[k-1]
                                       ? gen_xb[k+1] - gen_xb[k-1] : 0))
                       : longint'($signed(16'($urandom)));
                    gen_xb[k] = lv;
                    pending_items.push_back(mk_item(OP_LOAD_X, k, $urandom_range(15), lv,
                                            $urandom, $urandom));
                end
                else
                begin
                    lv = longint'($signed(16'($urandom)));
                    gen_yb[k] = lv;
                    pending_items.push_back(mk_item(OP_LOAD_Y, $urandom_range(15), k, lv,
                                            $urandom, $urandom));
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        // fill every entry before any lookup
        load_breaks(0);
        for (int j = 0; j < NPTS; j++)
            for (int i = 0; i < NPTS; i++)
                pending_items.push_back(mk_item(OP_LOAD_T, i, j,
                                        longint'($urandom_range(4096)) - 2048,
                                        $urandom, $urandom));
        for (int n = 0; n < 10; n++)
            add_lookup(pick_coord(2, gen_xb), pick_coord(2, gen_yb));
        wait_idle();
        write_cfg(2'd3, 5'd31);
        idle_pct = 25;
        run_phase(16, 16, MODE_EXTRAP, 3, 130);
        run_phase(16, 16, MODE_CLAMP, 0, 130);
        run_phase(5, 9, MODE_NEAREST, 1, 130);
        idle_pct = 69;
        run_phase(9, 5, MODE_BELOW, 0, 130);
        run_phase(0, 31, MODE_ABOVE, 1, 130);
        run_phase(17, 1, 5, 2, 130);
        idle_pct = 0;
        run_phase(2, 2, 7, 0, 130);
        run_phase(16, 3, 6, 3, 130);
        run_phase(31, 16, MODE_NEAREST, 0, 130);
        $display("covered %0d items and %0d checked lookups over all modes,", items_sent,
                 lookups_checked);
        $display("point counts in and out of range and several breakpoint layouts");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> bilinear_table_2d_lookup_unit.f
sv/bt2d_pkg.sv
sv/bt2d_ram.sv
sv/bt2d_divider.sv
sv/bilinear_table_2d_lookup_unit.sv
tb/bilinear_table_2d_lookup_unit_tb.sv
